// ===== rtl/allocation_misuse_checker_assert.svh =====
// Assertion macros for the allocation misuse checker.
`ifndef ALLOCATION_MISUSE_CHECKER_ASSERT_SVH
`define ALLOCATION_MISUSE_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside of reset.
`define AMC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("allocation checker assertion failed");

// Checks that a condition implies a consequence on the same clock edge.
`define AMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocation checker implication failed");

`else

`define AMC_ASSERT(label, clk, rst_n, prop)
`define AMC_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/amc_pkg.sv =====
// Types and constants shared by the allocation misuse checker modules.
`default_nettype none

package amc_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int ADDR_W = 64;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_SCAN  = 2'd2,
		MODE_NONE  = 2'd3
	} amc_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_NEW          = 4'd0,
		STAT_REALLOC      = 4'd1,
		STAT_DOUBLE_ALLOC = 4'd2,
		STAT_NULL_ALLOC   = 4'd3,
		STAT_FREED        = 4'd4,
		STAT_DOUBLE_FREE  = 4'd5,
		STAT_UNKNOWN_FREE = 4'd6,
		STAT_FULL         = 4'd7,
		STAT_LEAK         = 4'd8,
		STAT_CLEAN        = 4'd9
	} amc_status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_UPDATE = 2'd1,
		S_SCAN   = 2'd2
	} amc_state_t;

	typedef enum logic [2:0] {
		CELL_HOLD      = 3'd0,
		CELL_CMP       = 3'd1,
		CELL_INSERT    = 3'd2,
		CELL_SET_FREED = 3'd3,
		CELL_CLR_FREED = 3'd4,
		CELL_ROTATE    = 3'd5
	} amc_cell_op_t;

	typedef struct packed {
		amc_cell_op_t      op;
		logic [ADDR_W-1:0] key;
	} amc_cell_cmd_t;

	typedef struct packed {
		logic occ;
		logic tail;
		logic at_end;
	} amc_cell_pos_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              freed;
	} amc_entry_t;

endpackage

`default_nettype wire

// ===== rtl/amc_req_if.sv =====
// Event channel of the allocation misuse checker.
`default_nettype none

interface amc_req_if;
	logic                         valid;
	logic                         ready;
	logic [amc_pkg::MODE_W-1:0]   mode;
	logic [amc_pkg::ADDR_W-1:0]   address;

	modport source (output valid, output mode, output address, input ready);
	modport sink (input valid, input mode, input address, output ready);
endinterface

`default_nettype wire

// ===== rtl/amc_rsp_if.sv =====
// Report channel of the allocation misuse checker.
`default_nettype none

interface amc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [amc_pkg::STATUS_W-1:0] status;
	logic [amc_pkg::ADDR_W-1:0]   report_address;
	logic                         last;

	modport source (output valid, output status, output report_address, output last,
		input ready);
	modport sink (input valid, input status, input report_address, input last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/amc_cell.sv =====
// One table cell: holds an address and its freed mark, compares, shifts, rotates and sets or clears the mark.
`default_nettype none

module amc_cell (
	input  logic                   clk,
	input  amc_pkg::amc_cell_cmd_t cmd,
	input  amc_pkg::amc_cell_pos_t pos,
	input  amc_pkg::amc_entry_t    left,
	input  logic                   left_ge,
	input  amc_pkg::amc_entry_t    right,
	input  amc_pkg::amc_entry_t    head,
	output amc_pkg::amc_entry_t    entry,
	output logic                   ge,
	output logic                   eq
);
	import amc_pkg::*;

	amc_entry_t entry_q;
	logic       ge_q;
	logic       eq_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_CMP: begin
				ge_q <= pos.occ && (entry_q.addr >= cmd.key);
				eq_q <= pos.occ && (entry_q.addr == cmd.key);
			end
			CELL_INSERT: begin
				if (left_ge) begin
					entry_q <= left;
				end else if (ge_q || pos.at_end) begin
					entry_q.addr  <= cmd.key;
					entry_q.freed <= 1'b0;
				end
			end
			CELL_SET_FREED: begin
				if (eq_q) begin
					entry_q.freed <= 1'b1;
				end
			end
			CELL_CLR_FREED: begin
				if (eq_q) begin
					entry_q.freed <= 1'b0;
				end
			end
			CELL_ROTATE: begin
				if (pos.occ) begin
					entry_q <= pos.tail ? head : right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign ge    = ge_q;
	assign eq    = eq_q;

endmodule

`default_nettype wire

// ===== rtl/allocation_misuse_checker.sv =====
// Top level of the allocation misuse checker: control sequencer and the row of table cells.
//
// The checker keeps up to TABLE_DEPTH distinct addresses in a row of cells, sorted in
// ascending order, each marked allocated or freed. In an allocation or free transaction
// every cell compares its address with the event address in the accept cycle; then, once
// the output register is free, the row shifts right to insert a new address or updates
// the freed mark of the matching cell, and the single report is loaded into the output
// register. A leak scan rotates the occupied cells once through cell zero, one entry per
// cycle while the report channel does not stall. One event is processed at a time; the
// next event is taken while the last report still waits in the output register. Mode
// three is accepted and produces no report.
`default_nettype none

`include "allocation_misuse_checker_assert.svh"

module allocation_misuse_checker #(
	parameter int TABLE_DEPTH = amc_pkg::TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	amc_req_if.sink   req,
	amc_rsp_if.source rsp
);
	import amc_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	amc_state_t        state_q, state_d;
	amc_mode_t         mode_q;
	logic [ADDR_W-1:0] key_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     step_q;
	logic [ADDR_W-1:0] pend_q;
	logic              pend_valid_q;

	logic              out_valid_q;
	amc_status_t       out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_last_q;

	amc_entry_t              entry [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  ge;
	logic [TABLE_DEPTH-1:0]  eq;
	logic [TABLE_DEPTH-1:0]  eq_freed;
	amc_cell_cmd_t           cell_cmd;

	logic              accept;
	logic              slot_free;
	logic              found;
	logic              found_freed;
	logic              full;
	logic              head_leak;
	logic              scan_done;

	amc_cell_op_t      cell_op;
	logic              push;
	amc_status_t       push_status;
	logic [ADDR_W-1:0] push_addr;
	logic              push_last;
	logic              count_inc;
	logic              step_inc;
	logic              pend_load;
	logic              pend_clear;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		amc_cell_pos_t pos;
		amc_entry_t    left;
		logic          left_ge;
		amc_entry_t    right;

		assign pos.occ    = CW'(i) < count_q;
		assign pos.tail   = count_q == CW'(i + 1);
		assign pos.at_end = count_q == CW'(i);

		if (i == 0) begin : g_first
			assign left    = '0;
			assign left_ge = 1'b0;
		end else begin : g_inner_left
			assign left    = entry[i-1];
			assign left_ge = ge[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign right = entry[0];
		end else begin : g_inner_right
			assign right = entry[i+1];
		end

		assign eq_freed[i] = eq[i] && entry[i].freed;

		amc_cell u_cell (
			.clk     (clk),
			.cmd     (cell_cmd),
			.pos     (pos),
			.left    (left),
			.left_ge (left_ge),
			.right   (right),
			.head    (entry[0]),
			.entry   (entry[i]),
			.ge      (ge[i]),
			.eq      (eq[i])
		);
	end

	assign found       = |eq;
	assign found_freed = |eq_freed;
	assign full        = count_q == CW'(TABLE_DEPTH);
	assign head_leak   = !entry[0].freed;
	assign scan_done   = step_q == count_q;

	assign cell_cmd.op  = cell_op;
	assign cell_cmd.key = accept ? req.address : key_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (amc_mode_t'(req.mode))
						MODE_ALLOC: state_d = S_UPDATE;
						MODE_FREE:  state_d = S_UPDATE;
						MODE_SCAN:  state_d = S_SCAN;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_UPDATE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (scan_done && slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cell_op     = CELL_HOLD;
		push        = 1'b0;
		push_status = STAT_CLEAN;
		push_addr   = key_q;
		push_last   = 1'b1;
		count_inc   = 1'b0;
		step_inc    = 1'b0;
		pend_load   = 1'b0;
		pend_clear  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cell_op    = CELL_CMP;
					pend_clear = 1'b1;
				end
			end
			S_UPDATE: begin
				if (slot_free) begin
					push = 1'b1;
					if (mode_q == MODE_ALLOC) begin
						if (key_q == '0) begin
							push_status = STAT_NULL_ALLOC;
						end else if (found && found_freed) begin
							push_status = STAT_REALLOC;
							cell_op     = CELL_CLR_FREED;
						end else if (found) begin
							push_status = STAT_DOUBLE_ALLOC;
						end else if (full) begin
							push_status = STAT_FULL;
						end else begin
							push_status = STAT_NEW;
							cell_op     = CELL_INSERT;
							count_inc   = 1'b1;
						end
					end else begin
						if (found && !found_freed) begin
							push_status = STAT_FREED;
							cell_op     = CELL_SET_FREED;
						end else if (found) begin
							push_status = STAT_DOUBLE_FREE;
						end else begin
							push_status = STAT_UNKNOWN_FREE;
						end
					end
				end
			end
			S_SCAN: begin
				if (!scan_done) begin
					if (!head_leak) begin
						cell_op  = CELL_ROTATE;
						step_inc = 1'b1;
					end else if (!pend_valid_q || slot_free) begin
						cell_op   = CELL_ROTATE;
						step_inc  = 1'b1;
						pend_load = 1'b1;
						if (pend_valid_q) begin
							push        = 1'b1;
							push_status = STAT_LEAK;
							push_addr   = pend_q;
							push_last   = 1'b0;
						end
					end
				end else if (slot_free) begin
					push       = 1'b1;
					pend_clear = 1'b1;
					push_last  = 1'b1;
					if (pend_valid_q) begin
						push_status = STAT_LEAK;
						push_addr   = pend_q;
					end else begin
						push_status = STAT_CLEAN;
						push_addr   = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (accept) begin
				step_q <= '0;
			end else if (step_inc) begin
				step_q <= step_q + CW'(1);
			end
			if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end else if (pend_load) begin
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= amc_mode_t'(req.mode);
			key_q  <= req.address;
		end
		if (pend_load) begin
			pend_q <= entry[0].addr;
		end
		if (push) begin
			out_status_q <= push_status;
			out_addr_q   <= push_addr;
			out_last_q   <= push_last;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.report_address = out_addr_q;
	assign rsp.last           = out_last_q;

	`AMC_ASSERT(a_count_in_range, clk, arst_n, count_q <= CW'(TABLE_DEPTH))
	`AMC_ASSERT(a_step_in_range, clk, arst_n, step_q <= count_q)
	`AMC_ASSERT_IMPL(a_pend_only_in_scan, clk, arst_n, pend_valid_q, state_q == S_SCAN)
	`AMC_ASSERT_IMPL(a_count_grows_on_insert, clk, arst_n, count_q != $past(count_q), $past(cell_op == CELL_INSERT))

endmodule

`default_nettype wire
